[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Both macros expect signals named clk and rst_n in the scope of the use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk outside reset.
`define RRTD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define RRTD_ASSERT_IMP(name, cond, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/rrtd_pkg.sv]
`timescale 1ns / 1ps

package rrtd_pkg;

  // Texels in one 128 x 128 texture.
  localparam logic [14:0] TEXEL_COUNT = 15'd16384;

  // Input item: op 0 starts a texture, op 1 delivers a stream word.
  typedef struct packed {
    logic        op;
    logic [15:0] data_word;
  } in_item_t;

  // Result item: one span of texels sharing a colour.
  typedef struct packed {
    logic [13:0] span_start;
    logic [14:0] span_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        texture_complete;
  } out_item_t;

  // Op code values.
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

endpackage

[rtl/core/rrtd_in_reg.sv]
`timescale 1ns / 1ps

module rrtd_in_reg
  import rrtd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r;
  in_item_t item_r;

  // Capture a new transaction whenever the stage is empty or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  // The payload holds while the stage waits.
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[rtl/core/rrtd_decode.sv]
`timescale 1ns / 1ps

module rrtd_decode
  import rrtd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  in_item_t  item,
  input  logic      step_en,
  output logic      emit,
  output out_item_t span
);

  // Decoder phases.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_RAW   = 3'd1;
  localparam logic [2:0] PH_SKIP1 = 3'd2;
  localparam logic [2:0] PH_SKIP2 = 3'd3;
  localparam logic [2:0] PH_CTRL  = 3'd4;
  localparam logic [2:0] PH_LIT   = 3'd5;
  localparam logic [2:0] PH_REP   = 3'd6;
  localparam logic [2:0] PH_DONE  = 3'd7;

  logic        mode_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] run_r, run_nxt;
  logic [14:0] fill_r, fill_nxt;

  logic [14:0] left_w;
  logic [15:0] count_w;
  logic        clip_w;
  logic [14:0] len_w;
  logic [14:0] fill_sum_w;
  logic        emit_span;

  // Mode register, sampled when a start transaction is decoded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Span length: the requested count clipped to the texels still free.
  assign left_w     = TEXEL_COUNT - fill_r;
  assign count_w    = (phase_r == PH_REP) ? run_r : 16'd1;
  assign clip_w     = ({1'b0, left_w} <= count_w);
  assign len_w      = clip_w ? left_w : count_w[14:0];
  assign fill_sum_w = fill_r + len_w;

  // Next-state logic for one transaction.
  always_comb begin
    phase_nxt = phase_r;
    run_nxt   = run_r;
    fill_nxt  = fill_r;
    emit_span = 1'b0;
    if (item.op == OP_START) begin
      fill_nxt  = '0;
      run_nxt   = '0;
      phase_nxt = mode_r ? PH_SKIP1 : PH_RAW;
    end else begin
      unique case (phase_r)
        PH_RAW: begin
          emit_span = 1'b1;
        end
        PH_SKIP1: begin
          phase_nxt = PH_SKIP2;
        end
        PH_SKIP2: begin
          phase_nxt = PH_CTRL;
        end
        PH_CTRL: begin
          if (item.data_word[15:8] == 8'hFF) begin
            run_nxt   = 16'h0000 - item.data_word;
            phase_nxt = PH_LIT;
          end else begin
            run_nxt   = item.data_word;
            phase_nxt = PH_REP;
          end
        end
        PH_LIT: begin
          run_nxt   = run_r - 16'd1;
          emit_span = 1'b1;
          if (run_r == 16'd1) begin
            phase_nxt = PH_CTRL;
          end
        end
        PH_REP: begin
          phase_nxt = PH_CTRL;
          run_nxt   = '0;
          emit_span = (run_r != 16'd0);
        end
        PH_IDLE, PH_DONE: begin
        end
        default: begin
        end
      endcase
      // A span that reaches the last texel ends the texture.
      if (emit_span) begin
        fill_nxt = fill_sum_w;
        if (clip_w) begin
          phase_nxt = PH_DONE;
        end
      end
    end
  end

  // State registers advance once per decoded transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      run_r   <= '0;
      fill_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      run_r   <= run_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // Span payload: 5-5-5 colour widened to bytes, opaque alpha.
  assign emit                  = emit_span;
  assign span.span_start       = fill_r[13:0];
  assign span.span_length      = len_w;
  assign span.red              = {item.data_word[4:0], 3'b000};
  assign span.green            = {item.data_word[9:5], 3'b000};
  assign span.blue             = {item.data_word[14:10], 3'b000};
  assign span.alpha            = 8'hFF;
  assign span.texture_complete = clip_w;

endmodule

[rtl/core/rrtd_out_reg.sv]
`timescale 1ns / 1ps

module rrtd_out_reg
  import rrtd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      out_stall,
  input  logic      span_valid,
  input  out_item_t span,
  output logic      out_free,
  output logic      out_valid,
  output out_item_t out_data
);

  logic      valid_r;
  out_item_t data_r;

  // The register may take a new span when empty or when its span leaves.
  assign out_free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= span_valid;
    end
  end

  // A stalled span holds its payload.
  always_ff @(posedge clk) begin
    if (out_free && span_valid) begin
      data_r <= span;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[rtl/core/rle_rgb555_texture_decoder_top.sv]
`timescale 1ns / 1ps
// Run-length texture decoder, 5-5-5 colour words to 8-8-8-8 spans.
// Input channel (in_valid, in_stall, in_data): one transaction per stream
// word; op 0 starts a texture and latches the mode, op 1 carries a word.
// Result channel (out_valid, out_stall, out_data): one span (start, length,
// colour) for each word that writes texels; other words give nothing.
// Configuration: cfg_wr_en writes cfg_wr_data into the mode bit, which a
// start transaction samples. Write it only while the block is idle.
// Throughput is one transaction per cycle unless a span finds the output full. A
// transaction is held in the input register, decoded by the phase, run and fill
// registers in a single pass, and its span appears on out_valid the cycle after that.
// Transactions that give no span keep moving while the result channel is
// stalled; a span waits in the output register, and the input register
// holds one more transaction before in_stall rises.
// Reset (rst_n low at a clock edge) empties both registers, returns the
// decoder to idle, and clears the mode bit; words before a start are
// dropped.
`include "assert_macros.svh"

module rle_rgb555_texture_decoder_top
  import rrtd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      item_valid;
  in_item_t  item;
  logic      emit;
  out_item_t span;
  logic      out_free;
  logic      step_en;
  logic      load;

  // A held transaction is decoded unless its span would find the output full.
  assign step_en  = item_valid && (out_free || !emit);
  assign load     = !item_valid || step_en;
  assign in_stall = !load;

  rrtd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item)
  );

  rrtd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .step_en     (step_en),
    .emit        (emit),
    .span        (span)
  );

  rrtd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_stall  (out_stall),
    .span_valid (step_en && emit),
    .span       (span),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  // End of the delivered span, one past its last texel.
  logic [15:0] span_end;
  logic        span_at_end;
  logic        complete_out;
  assign span_end     = {2'b00, out_data.span_start} + {1'b0, out_data.span_length};
  assign span_at_end  = (span_end == {1'b0, TEXEL_COUNT});
  assign complete_out = out_valid && out_data.texture_complete;

  `RRTD_ASSERT_IMP(a_len_nonzero, out_valid, out_data.span_length != 15'd0, "empty span")
  `RRTD_ASSERT_IMP(a_span_in_range, out_valid, span_end <= {1'b0, TEXEL_COUNT}, "span past end")
  `RRTD_ASSERT_IMP(a_complete_at_end, complete_out, span_at_end, "complete flag off end")
  `RRTD_ASSERT(a_no_lost_span, !(emit && step_en && !out_free), "span dropped")

endmodule

[sim/rle_rgb555_texture_decoder_top_tb.sv]
`timescale 1ns / 1ps

module rle_rgb555_texture_decoder_top_tb;
  import rrtd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_WORDS  = 450;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned PRINT_LIMIT   = 40;

  // Decoder phases as the span predictor tracks them.
  typedef enum logic [2:0] {
    ST_IDLE, ST_RAW, ST_SIZE_LO, ST_SIZE_HI, ST_CONTROL, ST_LITERAL, ST_REPEAT, ST_DONE
  } dec_phase_t;

  // A directed row is either one transaction or a write of the mode bit.
  typedef enum logic {ROW_WORD, ROW_MODE} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    in_item_t  item;
    logic      has_want;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Predictor state.
  logic        mode_reg = 1'b0;
  dec_phase_t  dec_phase = ST_IDLE;
  logic [15:0] run_left = '0;
  logic [14:0] fill_pos = '0;
  logic        tex_full = 1'b0;

  out_item_t   pending_spans[$];
  dir_row_t    directed_rows[$];
  int unsigned words_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_request = 1'b0;

  rle_rgb555_texture_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Hard stop in case the block hangs.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Writes the texels of one span at the current fill position, clipped at the
  // end of the texture. Returns 0 when nothing is left to write.
  function automatic logic make_span(input logic [15:0] w, input logic [15:0] count,
                                     output out_item_t span);
    int unsigned room;
    int unsigned len;
    room = TEXEL_COUNT - fill_pos;
    len = (count < room) ? count : room;
    span = '0;
    if (len == 0) return 1'b0;
    span.span_start = fill_pos[13:0];
    span.span_length = 15'(len);
    fill_pos = fill_pos + 15'(len);
    if (fill_pos >= TEXEL_COUNT) begin
      tex_full = 1'b1;
      dec_phase = ST_DONE;
    end
    span.red = {w[4:0], 3'b000};
    span.green = {w[9:5], 3'b000};
    span.blue = {w[14:10], 3'b000};
    span.alpha = 8'hFF;
    span.texture_complete = tex_full;
    return 1'b1;
  endfunction

  // Advances the predictor by one transaction; returns 1 when a span is due.
  function automatic logic decode_word(input in_item_t it, output out_item_t span);
    logic got;
    got = 1'b0;
    span = '0;
    if (it.op == OP_START) begin
      fill_pos = '0;
      run_left = '0;
      tex_full = 1'b0;
      dec_phase = mode_reg ? ST_SIZE_LO : ST_RAW;
    end else if (!tex_full) begin
      case (dec_phase)
        ST_RAW: got = make_span(it.data_word, 16'd1, span);
        ST_SIZE_LO: dec_phase = ST_SIZE_HI;
        ST_SIZE_HI: dec_phase = ST_CONTROL;
        ST_CONTROL: begin
          if (it.data_word[15:8] == 8'hFF) begin
            run_left = 16'd0 - it.data_word;
            dec_phase = ST_LITERAL;
          end else begin
            run_left = it.data_word;
            dec_phase = ST_REPEAT;
          end
        end
        ST_LITERAL: begin
          run_left = run_left - 16'd1;
          if (run_left == 0) dec_phase = ST_CONTROL;
          got = make_span(it.data_word, 16'd1, span);
        end
        ST_REPEAT: begin
          dec_phase = ST_CONTROL;
          got = make_span(it.data_word, run_left, span);
          run_left = '0;
        end
        default: ;
      endcase
    end
    return got;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("ERROR cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got !== want) flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Offers one transaction after a random gap and waits until it is taken.
  // A typed span from the directed table replaces the predicted one.
  task automatic send_item(input in_item_t it, input logic has_want, input out_item_t want);
    out_item_t span;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(posedge clk);
    end while (in_stall);
    words_sent++;
    if (decode_word(it, span)) pending_spans.push_back(has_want ? want : span);
  endtask

  task automatic send_word(input logic op, input logic [15:0] w);
    in_item_t it;
    it.op = op;
    it.data_word = w;
    send_item(it, 1'b0, '0);
  endtask

  // Stops offering and waits until every span has come and the pipeline is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_reg = m;
  endtask

  // One texture: a start, then raw words or a compressed stream that is mostly
  // well formed, with the odd stray control word. It may end early.
  task automatic send_texture(input int unsigned n_words);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned cnt;
    stop_at = words_sent + n_words + 1;
    send_word(OP_START, 16'($urandom));
    if (dec_phase == ST_RAW) begin
      while (words_sent < stop_at) send_word(OP_DATA, 16'($urandom));
    end else begin
      send_word(OP_DATA, 16'($urandom));
      send_word(OP_DATA, 16'($urandom));
      while (words_sent < stop_at && !tex_full) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          cnt = $urandom_range(1, 6);
          send_word(OP_DATA, 16'(17'h10000 - cnt));
          repeat (cnt) begin
            if (!tex_full) send_word(OP_DATA, 16'($urandom));
          end
        end else if (pick < 90) begin
          cnt = (pick < 86) ? $urandom_range(0, 24) : $urandom_range(0, 16'hFEFF);
          send_word(OP_DATA, 16'(cnt));
          send_word(OP_DATA, 16'($urandom));
        end else begin
          send_word(OP_DATA, 16'($urandom));
        end
      end
    end
  endtask

  function automatic dir_row_t word_row(input logic op, input logic [15:0] w);
    dir_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.item.op = op;
    row.item.data_word = w;
    return row;
  endfunction

  function automatic dir_row_t span_row(input logic [15:0] w, input int unsigned st,
                                        input int unsigned len, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b,
                                        input logic done);
    dir_row_t row;
    row = word_row(OP_DATA, w);
    row.has_want = 1'b1;
    row.want.span_start = 14'(st);
    row.want.span_length = 15'(len);
    row.want.red = r;
    row.want.green = g;
    row.want.blue = b;
    row.want.alpha = 8'hFF;
    row.want.texture_complete = done;
    return row;
  endfunction

  function automatic dir_row_t mode_row(input logic m);
    dir_row_t row;
    row = '0;
    row.kind = ROW_MODE;
    row.item.data_word[0] = m;
    return row;
  endfunction

  // Receiver: random stalls, or one long hold-off counted here on request.
  initial begin : stall_driver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Each accepted span is compared with the oldest expected one.
  always @(posedge clk) begin : span_monitor
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_spans.size() == 0) begin
        flag_mismatch($sformatf("span at %0d with nothing expected", out_data.span_start));
      end else begin
        want = pending_spans.pop_front();
        check_field("span_start", out_data.span_start, want.span_start);
        check_field("span_length", out_data.span_length, want.span_length);
        check_field("red", out_data.red, want.red);
        check_field("green", out_data.green, want.green);
        check_field("blue", out_data.blue, want.blue);
        check_field("alpha", out_data.alpha, want.alpha);
        check_field("texture_complete", out_data.texture_complete, want.texture_complete);
      end
    end
  end

  initial begin : stimulus
    int unsigned blk;
    int unsigned block_end;

    directed_rows = '{
      // A word before any start is dropped.
      word_row(OP_DATA, 16'hFFFF),
      // Raw texture: colour extremes, one texel per word.
      word_row(OP_START, 16'hFFFF),
      span_row(16'h0000, 0, 1, 8'h00, 8'h00, 8'h00, 1'b0),
      span_row(16'hFFFF, 1, 1, 8'hF8, 8'hF8, 8'hF8, 1'b0),
      span_row(16'h001F, 2, 1, 8'hF8, 8'h00, 8'h00, 1'b0),
      span_row(16'h03E0, 3, 1, 8'h00, 8'hF8, 8'h00, 1'b0),
      span_row(16'h7C00, 4, 1, 8'h00, 8'h00, 8'hF8, 1'b0),
      // Switching to compressed mid-texture leaves the raw decode running.
      mode_row(1'b1),
      span_row(16'h8000, 5, 1, 8'h00, 8'h00, 8'h00, 1'b0),
      // Compressed: size words, a zero repeat, a short literal run.
      word_row(OP_START, 16'h0000),
      word_row(OP_DATA, 16'hAAAA),
      word_row(OP_DATA, 16'h5555),
      word_row(OP_DATA, 16'h0000),
      word_row(OP_DATA, 16'h7FFF),
      word_row(OP_DATA, 16'hFFFE),
      word_row(OP_DATA, 16'h1234),
      word_row(OP_DATA, 16'h4321),
      // Fill to one texel short, then finish inside a long literal run.
      word_row(OP_DATA, 16'h3FFD),
      word_row(OP_DATA, 16'h0421),
      word_row(OP_DATA, 16'hFF00),
      span_row(16'h7FFF, 16383, 1, 8'hF8, 8'hF8, 8'hF8, 1'b1),
      word_row(OP_DATA, 16'h2222),
      // Largest repeat count that is not a literal run, clipped to the texture.
      word_row(OP_START, 16'hFFFF),
      word_row(OP_DATA, 16'h0000),
      word_row(OP_DATA, 16'hFFFF),
      word_row(OP_DATA, 16'hFEFF),
      span_row(16'h0000, 0, 16384, 8'h00, 8'h00, 8'h00, 1'b1),
      word_row(OP_DATA, 16'h5A5A),
      mode_row(1'b0)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_MODE) begin
        settle();
        write_mode(directed_rows[i].item.data_word[0]);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].has_want, directed_rows[i].want);
      end
    end

    // Random part, in blocks that rotate the idle and stall pattern.
    words_sent = 0;
    blk = 0;
    while (words_sent < RANDOM_WORDS) begin
      settle();
      case (blk % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 78;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 78;
        end
        default: begin
          send_idle_pct = 16;
          stall_pct = 16;
        end
      endcase
      if (blk == 0) begin
        // Long receiver hold-off against a steady raw stream fills the block.
        write_mode(1'b0);
        hold_request = 1'b1;
        send_texture(24);
      end else begin
        write_mode($urandom_range(3) != 0);
        // Sometimes carry on the old texture under the mode it latched.
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 6)) send_word(OP_DATA, 16'($urandom));
        end
        block_end = words_sent + 60;
        while (words_sent < block_end) send_texture($urandom_range(4, 40));
      end
      blk++;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
